@@ design/assert_macros.svh @@
// assertion macros used by the csv field parser
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked at every clock edge out of reset
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ design/csv_pkg.sv @@
// types, constants and helper functions of the csv field parser
package csv_pkg;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       fend;
    logic       rend;
  } res_t;

  typedef struct packed {
    res_t       r0;
    res_t       r1;
    logic [1:0] n;
  } emit_t;

  function automatic res_t mk_res(logic [7:0] b, logic v, logic fe, logic re);
    res_t r;
    r.data  = v ? b : 8'h00;
    r.valid = v;
    r.fend  = fe;
    r.rend  = re;
    return r;
  endfunction

  // close a field with the first cnt held bytes, collapsing a quote pair
  function automatic emit_t flush(logic [1:0] cnt, logic re, logic [7:0] h0, logic [7:0] h1);
    emit_t e;
    e = '0;
    if (cnt == 2'd0) begin
      e.r0 = mk_res(8'h00, 1'b0, 1'b1, re);
      e.n  = 2'd1;
    end else if (cnt == 2'd1) begin
      e.r0 = mk_res(h0, 1'b1, 1'b1, re);
      e.n  = 2'd1;
    end else if (h0 == CH_QUOTE && h1 == CH_QUOTE) begin
      e.r0 = mk_res(CH_QUOTE, 1'b1, 1'b1, re);
      e.n  = 2'd1;
    end else begin
      e.r0 = mk_res(h0, 1'b1, 1'b0, 1'b0);
      e.r1 = mk_res(h1, 1'b1, 1'b1, re);
      e.n  = 2'd2;
    end
    return e;
  endfunction

endpackage

@@ design/csv_field_parser.sv @@
// csv field parser top level: byte parser and result queue
// Takes one record byte per transfer and streams field content bytes with field and record end
// marks; a quoted field loses its opening and final bytes and doubled quotes collapse. A byte is
// taken every cycle while the four-entry result queue has room for two results; each byte
// yields zero, one or two results, and the queue drains one result per cycle while out_ready
// is high, so the sustained rate is one byte per cycle whenever bytes average at most one result
// each and out_ready stays high. A result is written into the queue when its byte is taken.
`include "assert_macros.svh"

module csv_field_parser (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_record_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_field_end,
  output logic       out_record_end
);

  logic       quoted_r, quoted_nxt;
  logic       start_r, start_nxt;
  logic       parity_r, parity_nxt;
  logic       odd_r, odd_nxt;
  logic [1:0] hcnt_r, hcnt_nxt;
  logic [7:0] hold0_r, hold0_nxt;
  logic [7:0] hold1_r, hold1_nxt;

  csv_pkg::res_t                  fifo_r [csv_pkg::FIFO_DEPTH];
  logic [csv_pkg::PTR_W-1:0]      wp_r, wp_nxt;
  logic [csv_pkg::PTR_W-1:0]      rp_r, rp_nxt;
  logic [csv_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;

  csv_pkg::emit_t em;
  logic           in_xfer;
  logic           out_xfer;
  logic [1:0]     fl_cnt;
  csv_pkg::res_t  head;

  assign in_ready = (cnt_r <= csv_pkg::CNT_W'(csv_pkg::FIFO_DEPTH - 2));
  assign in_xfer  = in_valid && in_ready;
  assign out_valid = (cnt_r != '0);
  assign out_xfer  = out_valid && out_ready;

  assign head           = fifo_r[rp_r];
  assign out_byte       = head.data;
  assign out_byte_valid = head.valid;
  assign out_field_end  = head.fend;
  assign out_record_end = head.rend;

  assign fl_cnt = (hcnt_r != 2'd0) ? hcnt_r - 2'd1 : 2'd0;

  // per-byte parse
  always_comb begin
    quoted_nxt = quoted_r;
    start_nxt  = start_r;
    parity_nxt = parity_r;
    odd_nxt    = odd_r;
    hcnt_nxt   = hcnt_r;
    hold0_nxt  = hold0_r;
    hold1_nxt  = hold1_r;
    em         = '0;
    if (quoted_r) begin
      if (odd_r && in_byte == csv_pkg::CH_COMMA) begin
        em = csv_pkg::flush(fl_cnt, 1'b0, hold0_r, hold1_r);
        if (in_record_last) begin
          em.r1 = csv_pkg::mk_res(8'h00, 1'b0, 1'b1, 1'b1);
          em.n  = 2'd2;
        end
        quoted_nxt = 1'b0;
        start_nxt  = 1'b1;
        parity_nxt = 1'b0;
        odd_nxt    = 1'b0;
        hcnt_nxt   = 2'd0;
      end else if (in_record_last) begin
        em         = csv_pkg::flush(hcnt_r, 1'b1, hold0_r, hold1_r);
        quoted_nxt = 1'b0;
        start_nxt  = 1'b1;
        parity_nxt = 1'b0;
        odd_nxt    = 1'b0;
        hcnt_nxt   = 2'd0;
      end else begin
        if (in_byte == csv_pkg::CH_QUOTE) begin
          parity_nxt = ~parity_r;
          odd_nxt    = ~parity_r;
        end else begin
          odd_nxt = 1'b0;
        end
        if (hcnt_r == 2'd2) begin
          em.r0 = csv_pkg::mk_res(hold0_r, 1'b1, 1'b0, 1'b0);
          em.n  = 2'd1;
          if (hold0_r == csv_pkg::CH_QUOTE && hold1_r == csv_pkg::CH_QUOTE) begin
            hold0_nxt = in_byte;
            hcnt_nxt  = 2'd1;
          end else begin
            hold0_nxt = hold1_r;
            hold1_nxt = in_byte;
          end
        end else if (hcnt_r == 2'd1) begin
          hold1_nxt = in_byte;
          hcnt_nxt  = 2'd2;
        end else begin
          hold0_nxt = in_byte;
          hcnt_nxt  = 2'd1;
        end
      end
    end else if (start_r && in_byte == csv_pkg::CH_QUOTE) begin
      if (in_record_last) begin
        em.r0 = csv_pkg::mk_res(8'h00, 1'b0, 1'b1, 1'b1);
        em.n  = 2'd1;
      end else begin
        quoted_nxt = 1'b1;
        start_nxt  = 1'b0;
        parity_nxt = 1'b0;
        odd_nxt    = 1'b0;
        hcnt_nxt   = 2'd0;
      end
    end else if (in_byte == csv_pkg::CH_COMMA) begin
      em.r0 = csv_pkg::mk_res(8'h00, 1'b0, 1'b1, 1'b0);
      em.n  = 2'd1;
      if (in_record_last) begin
        em.r1 = csv_pkg::mk_res(8'h00, 1'b0, 1'b1, 1'b1);
        em.n  = 2'd2;
      end
      start_nxt  = 1'b1;
      parity_nxt = 1'b0;
      odd_nxt    = 1'b0;
      hcnt_nxt   = 2'd0;
    end else begin
      em.r0     = csv_pkg::mk_res(in_byte, 1'b1, in_record_last, in_record_last);
      em.n      = 2'd1;
      start_nxt = in_record_last;
    end
  end

  // result queue pointers
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (in_xfer) begin
      wp_nxt = wp_r + csv_pkg::PTR_W'(em.n);
    end
    if (out_xfer) begin
      rp_nxt = rp_r + 1'b1;
    end
    cnt_nxt = cnt_r + (in_xfer ? csv_pkg::CNT_W'(em.n) : '0)
            - (out_xfer ? csv_pkg::CNT_W'(1) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quoted_r <= 1'b0;
      start_r  <= 1'b1;
      parity_r <= 1'b0;
      odd_r    <= 1'b0;
      hcnt_r   <= 2'd0;
      wp_r     <= '0;
      rp_r     <= '0;
      cnt_r    <= '0;
    end else begin
      if (in_xfer) begin
        quoted_r <= quoted_nxt;
        start_r  <= start_nxt;
        parity_r <= parity_nxt;
        odd_r    <= odd_nxt;
        hcnt_r   <= hcnt_nxt;
      end
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      hold0_r <= hold0_nxt;
      hold1_r <= hold1_nxt;
      if (em.n != 2'd0) begin
        fifo_r[wp_r] <= em.r0;
      end
      if (em.n == 2'd2) begin
        fifo_r[wp_r + 1'b1] <= em.r1;
      end
    end
  end

  `ASSERT_ALWAYS(a_cnt_bound, cnt_r <= csv_pkg::CNT_W'(csv_pkg::FIFO_DEPTH), "queue overflow")
  `ASSERT_ALWAYS(a_hcnt_bound, hcnt_r != 2'd3, "hold count out of range")
  `ASSERT_IMPLY(a_hold_empty, !quoted_r, hcnt_r == 2'd0, "bytes held outside quoted mode")
  `ASSERT_IMPLY(a_rec_field, out_valid && out_record_end, out_field_end, "lone record end")
  `ASSERT_ALWAYS(a_ptr_gap, wp_r == rp_r + csv_pkg::PTR_W'(cnt_r), "queue pointers off")

endmodule

@@ tb/tb_top.sv @@
// testbench for csv_field_parser: directed byte table, random records, field predictor
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS = 950;
  localparam int LIMIT = 200000;
  localparam int HOLD_CYCLES = 100;

  typedef struct {
    logic [7:0]    b;
    logic          last;
    bit            typed;
    int            n;
    csv_pkg::res_t r0;
    csv_pkg::res_t r1;
  } dir_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       in_record_last;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_field_end;
  logic       out_record_end;

  csv_field_parser u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .in_record_last(in_record_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_byte_valid(out_byte_valid),
    .out_field_end (out_field_end),
    .out_record_end(out_record_end)
  );

  // parser state of the predictor
  bit         q_mode;
  bit         at_start;
  bit         parity;
  bit         odd_quote;
  logic [7:0] hold [2];
  int         hold_cnt;

  csv_pkg::res_t step_res[$];
  csv_pkg::res_t pending_results[$];
  dir_row_t      dir_rows[$];

  bit            drv_typed;
  int            drv_n;
  csv_pkg::res_t drv_r0;
  csv_pkg::res_t drv_r1;

  int cycle_cnt;
  int accepted_cnt;
  int result_cnt;
  int record_cnt;
  int quoted_cnt;
  int errors;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic csv_pkg::res_t res_of(logic [7:0] b, logic v, logic fe, logic re);
    csv_pkg::res_t r;
    r.data  = v ? b : 8'h00;
    r.valid = v;
    r.fend  = fe;
    r.rend  = re;
    return r;
  endfunction

  function automatic bit idling();
    return !((accepted_cnt >= 250 && accepted_cnt < 350) || accepted_cnt >= 850);
  endfunction

  task automatic push_res(logic [7:0] b, logic v, logic fe, logic re);
    step_res.insert(step_res.size(), res_of(b, v, fe, re));
  endtask

  task automatic clear_field();
    q_mode    = 1'b0;
    at_start  = 1'b1;
    parity    = 1'b0;
    odd_quote = 1'b0;
    hold_cnt  = 0;
  endtask

  // close the field with the first cnt held bytes, a held quote pair becomes one quote
  task automatic close_field(int cnt, logic re);
    if (cnt == 0) begin
      push_res(8'h00, 1'b0, 1'b1, re);
    end else if (cnt == 1) begin
      push_res(hold[0], 1'b1, 1'b1, re);
    end else if (hold[0] == csv_pkg::CH_QUOTE && hold[1] == csv_pkg::CH_QUOTE) begin
      push_res(csv_pkg::CH_QUOTE, 1'b1, 1'b1, re);
    end else begin
      push_res(hold[0], 1'b1, 1'b0, 1'b0);
      push_res(hold[1], 1'b1, 1'b1, re);
    end
  endtask

  task automatic parse_byte(logic [7:0] b, logic last);
    step_res.delete();
    if (q_mode) begin
      if (odd_quote && b == csv_pkg::CH_COMMA) begin
        close_field(hold_cnt > 0 ? hold_cnt - 1 : 0, 1'b0);
        clear_field();
        if (last) push_res(8'h00, 1'b0, 1'b1, 1'b1);
        return;
      end
      if (last) begin
        close_field(hold_cnt, 1'b1);
        clear_field();
        return;
      end
      if (b == csv_pkg::CH_QUOTE) begin
        parity    = ~parity;
        odd_quote = parity;
      end else begin
        odd_quote = 1'b0;
      end
      if (hold_cnt >= 2) begin
        push_res(hold[0], 1'b1, 1'b0, 1'b0);
        if (hold[0] == csv_pkg::CH_QUOTE && hold[1] == csv_pkg::CH_QUOTE) begin
          hold[0]  = b;
          hold_cnt = 1;
        end else begin
          hold[0] = hold[1];
          hold[1] = b;
        end
      end else begin
        hold[hold_cnt] = b;
        hold_cnt++;
      end
      return;
    end
    if (at_start && b == csv_pkg::CH_QUOTE) begin
      if (last) begin
        push_res(8'h00, 1'b0, 1'b1, 1'b1);
        clear_field();
        return;
      end
      q_mode    = 1'b1;
      at_start  = 1'b0;
      parity    = 1'b0;
      odd_quote = 1'b0;
      hold_cnt  = 0;
      quoted_cnt++;
      return;
    end
    if (b == csv_pkg::CH_COMMA) begin
      push_res(8'h00, 1'b0, 1'b1, 1'b0);
      clear_field();
      if (last) push_res(8'h00, 1'b0, 1'b1, 1'b1);
      return;
    end
    at_start = 1'b0;
    if (last) begin
      push_res(b, 1'b1, 1'b1, 1'b1);
      clear_field();
    end else begin
      push_res(b, 1'b1, 1'b0, 1'b0);
    end
  endtask

  // transfer sampling, prediction and result check
  always @(posedge clk) begin
    csv_pkg::res_t got;
    csv_pkg::res_t want;
    cycle_cnt++;
    if (cycle_cnt == LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $realtime, cycle_cnt, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end else if (rst_n) begin
      if (in_valid && in_ready) begin
        parse_byte(in_byte, in_record_last);
        if (drv_typed) begin
          if (drv_n > 0) pending_results.insert(pending_results.size(), drv_r0);
          if (drv_n > 1) pending_results.insert(pending_results.size(), drv_r1);
        end else begin
          foreach (step_res[i]) pending_results.insert(pending_results.size(), step_res[i]);
        end
        accepted_cnt++;
        if (in_record_last) record_cnt++;
      end
      if (out_valid && out_ready) begin
        got = res_of(out_byte, out_byte_valid, out_field_end, out_record_end);
        got.data = out_byte;
        result_cnt++;
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got byte %h valid %b fe %b re %b",
                   $realtime, got.data, got.valid, got.fend, got.rend);
        end else begin
          want = pending_results.pop_front();
          if (got.data !== want.data || got.valid !== want.valid ||
              got.fend !== want.fend || got.rend !== want.rend) begin
            errors++;
            $display("%0t: result mismatch, expected byte %h valid %b fe %b re %b,",
                     $realtime, want.data, want.valid, want.fend, want.rend,
                     " got byte %h valid %b fe %b re %b",
                     got.data, got.valid, got.fend, got.rend);
          end
        end
      end
    end
  end

  // receiver: short random stalls and one long hold-off
  initial begin
    bit held;
    held = 1'b0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && accepted_cnt >= 500) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_ready <= 1'b1;
      end else if (idling() && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic last, bit typed, int n,
                           csv_pkg::res_t r0, csv_pkg::res_t r1);
    if (idling() && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_byte        <= b;
    in_record_last <= last;
    drv_typed = typed;
    drv_n     = n;
    drv_r0    = r0;
    drv_r1    = r1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic add_row(logic [7:0] b, logic last, bit typed, int n,
                         csv_pkg::res_t r0, csv_pkg::res_t r1);
    dir_row_t row;
    row.b     = b;
    row.last  = last;
    row.typed = typed;
    row.n     = n;
    row.r0    = r0;
    row.r1    = r1;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == csv_pkg::CH_COMMA || b == csv_pkg::CH_QUOTE) b = b ^ 8'h40;
    return b;
  endfunction

  function automatic logic [7:0] noisy_byte();
    int pick;
    pick = $urandom_range(0, 4);
    if (pick == 0) return csv_pkg::CH_COMMA;
    if (pick == 1) return csv_pkg::CH_QUOTE;
    return 8'($urandom_range(0, 255));
  endfunction

  // one record: mostly well-formed fields, sometimes damaged or pure noise
  task automatic send_record();
    logic [7:0] rec[$];
    int nf;
    int len;
    int pos;
    if ($urandom_range(0, 6) == 0) begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        send_byte(noisy_byte(), (i == len - 1) || ($urandom_range(0, 7) == 0),
                  1'b0, 0, '0, '0);
      end
      return;
    end
    nf = $urandom_range(1, 4);
    for (int f = 0; f < nf; f++) begin
      if (f > 0) rec.insert(rec.size(), csv_pkg::CH_COMMA);
      len = $urandom_range(0, 5);
      if ($urandom_range(0, 2) == 0) begin
        for (int i = 0; i < len; i++) begin
          if (i > 0 && $urandom_range(0, 7) == 0) rec.insert(rec.size(), csv_pkg::CH_QUOTE);
          else rec.insert(rec.size(), plain_byte());
        end
      end else begin
        rec.insert(rec.size(), csv_pkg::CH_QUOTE);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(0, 5))
            0: begin
              rec.insert(rec.size(), csv_pkg::CH_QUOTE);
              rec.insert(rec.size(), csv_pkg::CH_QUOTE);
            end
            1: rec.insert(rec.size(), csv_pkg::CH_COMMA);
            default: rec.insert(rec.size(), plain_byte());
          endcase
        end
        rec.insert(rec.size(), csv_pkg::CH_QUOTE);
      end
    end
    if ($urandom_range(0, 7) == 0) rec.insert(rec.size(), csv_pkg::CH_COMMA);
    if ($urandom_range(0, 9) == 0 && rec.size() > 0) begin
      pos = $urandom_range(0, rec.size() - 1);
      if ($urandom_range(0, 1) == 0) rec.delete(pos);
      else rec.insert(pos, noisy_byte());
    end
    if (rec.size() == 0) rec.insert(0, plain_byte());
    foreach (rec[i]) send_byte(rec[i], i == rec.size() - 1, 1'b0, 0, '0, '0);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_byte        = 8'h00;
    in_record_last = 1'b0;
    drv_typed      = 1'b0;
    drv_n          = 0;
    drv_r0         = '0;
    drv_r1         = '0;
    cycle_cnt      = 0;
    accepted_cnt   = 0;
    result_cnt     = 0;
    record_cnt     = 0;
    quoted_cnt     = 0;
    errors         = 0;
    hold[0]        = 8'h00;
    hold[1]        = 8'h00;
    clear_field();

    // plain bytes, trailing comma, lone quote, byte extremes
    add_row(8'h61, 1'b0, 1'b1, 1, res_of(8'h61, 1'b1, 1'b0, 1'b0), '0);
    add_row(csv_pkg::CH_COMMA, 1'b1, 1'b1, 2, res_of(8'h00, 1'b0, 1'b1, 1'b0),
            res_of(8'h00, 1'b0, 1'b1, 1'b1));
    add_row(csv_pkg::CH_QUOTE, 1'b1, 1'b1, 1, res_of(8'h00, 1'b0, 1'b1, 1'b1), '0);
    add_row(8'h00, 1'b1, 1'b1, 1, res_of(8'h00, 1'b1, 1'b1, 1'b1), '0);
    add_row(8'hFF, 1'b0, 1'b1, 1, res_of(8'hFF, 1'b1, 1'b0, 1'b0), '0);
    // quote inside an unquoted field
    add_row(csv_pkg::CH_QUOTE, 1'b0, 1'b1, 1, res_of(csv_pkg::CH_QUOTE, 1'b1, 1'b0, 1'b0), '0);
    add_row(csv_pkg::CH_COMMA, 1'b1, 1'b1, 2, res_of(8'h00, 1'b0, 1'b1, 1'b0),
            res_of(8'h00, 1'b0, 1'b1, 1'b1));
    // quoted field with a doubled quote, closed by a comma
    add_row(csv_pkg::CH_QUOTE, 1'b0, 1'b1, 0, '0, '0);
    add_row(8'h78, 1'b0, 1'b0, 0, '0, '0);
    add_row(csv_pkg::CH_QUOTE, 1'b0, 1'b0, 0, '0, '0);
    add_row(csv_pkg::CH_QUOTE, 1'b0, 1'b0, 0, '0, '0);
    add_row(8'h79, 1'b0, 1'b0, 0, '0, '0);
    add_row(csv_pkg::CH_QUOTE, 1'b0, 1'b0, 0, '0, '0);
    add_row(csv_pkg::CH_COMMA, 1'b0, 1'b0, 0, '0, '0);
    // quoted field too short to hold content
    add_row(csv_pkg::CH_QUOTE, 1'b0, 1'b0, 0, '0, '0);
    add_row(csv_pkg::CH_QUOTE, 1'b1, 1'b1, 1, res_of(8'h00, 1'b0, 1'b1, 1'b1), '0);
    // comma as last byte inside quotes is dropped
    add_row(csv_pkg::CH_QUOTE, 1'b0, 1'b0, 0, '0, '0);
    add_row(8'h61, 1'b0, 1'b0, 0, '0, '0);
    add_row(csv_pkg::CH_COMMA, 1'b1, 1'b1, 1, res_of(8'h61, 1'b1, 1'b1, 1'b1), '0);
    // odd quote then comma as last byte
    add_row(csv_pkg::CH_QUOTE, 1'b0, 1'b0, 0, '0, '0);
    add_row(8'h62, 1'b0, 1'b0, 0, '0, '0);
    add_row(csv_pkg::CH_QUOTE, 1'b0, 1'b0, 0, '0, '0);
    add_row(csv_pkg::CH_COMMA, 1'b1, 1'b0, 0, '0, '0);
    add_row(8'hFF, 1'b1, 1'b1, 1, res_of(8'hFF, 1'b1, 1'b1, 1'b1), '0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].b, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].n,
                dir_rows[i].r0, dir_rows[i].r1);
    end
    while (accepted_cnt < ITEMS) send_record();
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("run covered %0d byte transfers in %0d records (%0d quoted fields)",
             accepted_cnt, record_cnt, quoted_cnt);
    $display("%0d result transfers checked, %0d mismatches", result_cnt, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
